// ===== src/i2a_pkg.sv =====
package i2a_pkg;

  localparam int VALUE_WIDTH = 64;
  localparam int STORE_DEPTH = 20;
  localparam int DIG_BITS = STORE_DEPTH * 4;
  localparam int DIGIT_IDX_W = $clog2(STORE_DEPTH);
  // Magnitude bits are consumed four per conversion step.
  localparam int BITS_PER_STEP = 4;
  localparam int PAD_WIDTH = ((VALUE_WIDTH + BITS_PER_STEP - 1) / BITS_PER_STEP) * BITS_PER_STEP;
  localparam int CONV_STEPS = PAD_WIDTH / BITS_PER_STEP;
  localparam int STEP_CNT_W = $clog2(CONV_STEPS + 1);

  localparam logic [1:0] FMT_SDEC = 2'd0;
  localparam logic [1:0] FMT_UDEC = 2'd1;
  localparam logic [1:0] FMT_HEX  = 2'd2;

  localparam logic [6:0] CHAR_ZERO  = 7'h30;
  localparam logic [6:0] CHAR_X     = 7'h78;
  localparam logic [6:0] CHAR_MINUS = 7'h2d;
  localparam logic [6:0] CHAR_LA    = 7'h61;
  localparam logic [3:0] RADIX_DEC  = 4'd10;

  typedef enum logic [1:0] {
    SEL_ZERO,
    SEL_X,
    SEL_MINUS,
    SEL_DIGIT
  } sel_t;

  typedef struct packed {
    logic load;
    logic step;
    logic count;
    logic emit;
    sel_t sel;
    logic last;
  } cmd_t;

  typedef struct packed {
    logic hex;
    logic neg;
    logic steps_one;
    logic idx_zero;
    logic out_free;
  } stat_t;

endpackage

// ===== src/integer_to_ascii_formatter.sv =====
// Formats one integer item as ASCII text, one character per output item, most
// significant first, with last set on the final character. action selects signed
// decimal (leading '-' when negative), unsigned decimal, or hex with a "0x"
// prefix and lowercase digits; codes with the high bit set format as hex. No
// leading zeros are written and at least one digit always is. A decimal item is
// accepted, converted in the binary-to-BCD unit (four bits per cycle through the
// shift-and-add-3 loop), its leading digit is found, and then its characters are
// sent one after another while the output is taken. A hex item skips the BCD
// unit. One item is worked on at a time; the next one is accepted as soon as the
// final character has entered the output register.
module integer_to_ascii_formatter
  import i2a_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  action,
  input  logic [63:0] value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [6:0]  char_code,
  output logic        last
);

  cmd_t  cmd;
  stat_t stat;

  i2a_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  i2a_dpath u_dpath (
    .clk       (clk),
    .rst       (rst),
    .action    (action),
    .value     (value),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .char_code (char_code),
    .last      (last)
  );

endmodule

// ===== src/i2a_ctrl.sv =====
module i2a_ctrl
  import i2a_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  stat_t stat,
  output cmd_t  cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_COUNT,
    ST_PFX0,
    ST_PFXX,
    ST_MINUS,
    ST_DIGITS
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = (state == ST_IDLE);

  always_comb begin
    state_next = state;
    cmd = '0;
    cmd.sel = SEL_DIGIT;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          state_next = ST_CONV;
        end
      end
      ST_CONV: begin
        // Hex digits are loaded directly, so the add-3 loop is skipped.
        if (stat.hex) begin
          state_next = ST_COUNT;
        end else begin
          cmd.step = 1'b1;
          if (stat.steps_one) begin
            state_next = ST_COUNT;
          end
        end
      end
      ST_COUNT: begin
        cmd.count = 1'b1;
        if (stat.hex) begin
          state_next = ST_PFX0;
        end else if (stat.neg) begin
          state_next = ST_MINUS;
        end else begin
          state_next = ST_DIGITS;
        end
      end
      ST_PFX0: begin
        cmd.sel = SEL_ZERO;
        if (stat.out_free) begin
          cmd.emit = 1'b1;
          state_next = ST_PFXX;
        end
      end
      ST_PFXX: begin
        cmd.sel = SEL_X;
        if (stat.out_free) begin
          cmd.emit = 1'b1;
          state_next = ST_DIGITS;
        end
      end
      ST_MINUS: begin
        cmd.sel = SEL_MINUS;
        if (stat.out_free) begin
          cmd.emit = 1'b1;
          state_next = ST_DIGITS;
        end
      end
      ST_DIGITS: begin
        cmd.sel = SEL_DIGIT;
        cmd.last = stat.idx_zero;
        if (stat.out_free) begin
          cmd.emit = 1'b1;
          if (stat.idx_zero) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  a_load_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("controller stayed idle after taking an item");

  a_emit_needs_room: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> stat.out_free)
    else $error("character emitted while output register is full");

  a_no_emit_idle: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !cmd.emit && !cmd.step)
    else $error("datapath command issued while idle");

  a_last_only_digit: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit && cmd.last) |-> (cmd.sel == SEL_DIGIT))
    else $error("prefix character flagged as last");

endmodule

// ===== src/i2a_dpath.sv =====
module i2a_dpath
  import i2a_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic [1:0]             action,
  input  logic [63:0]            value,
  input  cmd_t                   cmd,
  output stat_t                  stat,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [6:0]             char_code,
  output logic                   last
);

  logic [STORE_DEPTH-1:0][3:0] digits;
  logic [PAD_WIDTH-1:0]        shift_in;
  logic [STEP_CNT_W-1:0]       step_cnt;
  logic [DIGIT_IDX_W-1:0]      digit_idx;
  logic                        hex;
  logic                        neg;

  logic [VALUE_WIDTH-1:0]      v;
  logic                        v_neg;
  logic [VALUE_WIDTH-1:0]      mag;
  logic [STORE_DEPTH-1:0][3:0] digits_step;
  logic [PAD_WIDTH-1:0]        shift_step;
  logic [DIGIT_IDX_W-1:0]      top_idx;
  logic [3:0]                  cur_digit;
  logic [6:0]                  digit_char;
  logic [6:0]                  sel_char;

  assign v = value[VALUE_WIDTH-1:0];
  assign v_neg = (action == FMT_SDEC) && v[VALUE_WIDTH-1];
  // The most negative value negates to itself, which read unsigned is its magnitude.
  assign mag = v_neg ? (~v + {{(VALUE_WIDTH-1){1'b0}}, 1'b1}) : v;

  // Four rounds of shift-and-add-3, one magnitude bit per round.
  always_comb begin
    digits_step = digits;
    shift_step = shift_in;
    for (int j = 0; j < BITS_PER_STEP; j++) begin
      for (int i = 0; i < STORE_DEPTH; i++) begin
        if (digits_step[i] >= 4'd5) begin
          digits_step[i] = digits_step[i] + 4'd3;
        end
      end
      {digits_step, shift_step} = {digits_step, shift_step} << 1;
    end
  end

  always_comb begin
    top_idx = '0;
    for (int i = 0; i < STORE_DEPTH; i++) begin
      if (digits[i] != 4'd0) begin
        top_idx = DIGIT_IDX_W'(i);
      end
    end
  end

  assign cur_digit = digits[digit_idx];
  assign digit_char = (cur_digit < RADIX_DEC) ? (CHAR_ZERO + {3'b000, cur_digit})
                                              : (CHAR_LA + {3'b000, cur_digit} - 7'd10);

  always_comb begin
    unique case (cmd.sel)
      SEL_ZERO:  sel_char = CHAR_ZERO;
      SEL_X:     sel_char = CHAR_X;
      SEL_MINUS: sel_char = CHAR_MINUS;
      SEL_DIGIT: sel_char = digit_char;
      default:   sel_char = digit_char;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      hex <= action[1];
      neg <= v_neg;
      step_cnt <= STEP_CNT_W'(CONV_STEPS);
      if (action[1]) begin
        digits <= DIG_BITS'(mag);
      end else begin
        digits <= '0;
      end
      shift_in <= PAD_WIDTH'(mag);
    end else if (cmd.step) begin
      digits <= digits_step;
      shift_in <= shift_step;
      step_cnt <= step_cnt - 1'b1;
    end
    if (cmd.count) begin
      digit_idx <= top_idx;
    end else if (cmd.emit && cmd.sel == SEL_DIGIT) begin
      digit_idx <= digit_idx - 1'b1;
    end
    if (cmd.emit) begin
      char_code <= sel_char;
      last <= cmd.last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  assign stat.hex = hex;
  assign stat.neg = neg;
  assign stat.steps_one = (step_cnt == STEP_CNT_W'(1));
  assign stat.idx_zero = (digit_idx == '0);
  assign stat.out_free = !out_valid || out_ready;

  a_idx_in_range: assert property (@(posedge clk) disable iff (rst)
    cmd.count |=> (digit_idx < DIGIT_IDX_W'(STORE_DEPTH)))
    else $error("leading digit index beyond the digit store");

  a_step_not_exhausted: assert property (@(posedge clk) disable iff (rst)
    cmd.step |-> (step_cnt != '0))
    else $error("conversion step issued after all bits were consumed");

endmodule

// ===== tb/sv/integer_to_ascii_formatter_checker.sv =====
module integer_to_ascii_formatter_checker
  import i2a_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [1:0]  action,
  input  logic [63:0] value,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [6:0]  char_code,
  input  logic        last,
  output int          errors,
  output int          pending
);

  typedef struct {
    logic [6:0] code;
    logic       fin;
    int         item;
  } glyph_t;

  glyph_t text_q[$];
  int     items_in = 0;

  initial errors = 0;
  assign pending = text_q.size();

  task automatic report_mismatch(string what);
    if (errors < 40) begin
      $display("[%0d] mismatch: %s", $time, what);
    end
    errors++;
  endtask

  // Builds the expected text of one number and queues it, one entry per character.
  function automatic void format_number(logic [1:0] fmt, logic [63:0] raw, int item);
    logic [63:0] mask;
    logic [63:0] num;
    logic [63:0] mag;
    logic [63:0] radix;
    logic        as_hex;
    logic        minus;
    logic [3:0]  digits[$];
    logic [6:0]  text[$];
    glyph_t      g;

    mask   = {64{1'b1}} >> (64 - VALUE_WIDTH);
    num    = raw & mask;
    as_hex = fmt[1];
    minus  = (fmt == FMT_SDEC) && num[VALUE_WIDTH-1];
    mag    = minus ? ((~num + 64'd1) & mask) : num;
    radix  = as_hex ? 64'd16 : 64'd10;

    do begin
      digits.push_back(4'(mag % radix));
      mag = mag / radix;
    end while (mag != 0 && digits.size() < STORE_DEPTH);

    if (as_hex) begin
      text.push_back(CHAR_ZERO);
      text.push_back(CHAR_X);
    end else if (minus) begin
      text.push_back(CHAR_MINUS);
    end
    for (int i = digits.size() - 1; i >= 0; i--) begin
      if (digits[i] < 4'd10) text.push_back(CHAR_ZERO + 7'(digits[i]));
      else text.push_back(CHAR_LA + 7'(digits[i] - 4'd10));
    end

    foreach (text[i]) begin
      g.code = text[i];
      g.fin  = (i == text.size() - 1);
      g.item = item;
      text_q.push_back(g);
    end
  endfunction

  always @(posedge clk) begin
    glyph_t want;
    if (!rst) begin
      // New expectations go to the back, so the same-edge order does not matter.
      if (in_valid && in_ready) begin
        format_number(action, value, items_in);
        items_in++;
      end
      if (out_valid && out_ready) begin
        if (text_q.size() == 0) begin
          report_mismatch($sformatf("character 0x%02h with no text pending", char_code));
        end else begin
          want = text_q.pop_front();
          if (char_code !== want.code)
            report_mismatch($sformatf("item %0d: char_code 0x%02h, expected 0x%02h",
                                      want.item, char_code, want.code));
          if (last !== want.fin)
            report_mismatch($sformatf("item %0d: last %0b, expected %0b",
                                      want.item, last, want.fin));
        end
      end
    end
  end

endmodule

// ===== tb/sv/integer_to_ascii_formatter_tb.sv =====
module integer_to_ascii_formatter_tb
  import i2a_pkg::*;
();

  localparam int HOLD_CYCLES = 300;
  // The format code left unused; the block treats it as hex.
  localparam logic [1:0] FMT_UNUSED = 2'd3;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  action = FMT_SDEC;
  logic [63:0] value = 64'd0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [6:0]  char_code;
  logic        last;

  int errors;
  int pending;

  bit tx_quiet  = 1'b0;
  bit rx_steady = 1'b0;
  bit hold_req  = 1'b0;
  int stall_left = 0;

  always #1 clk = ~clk;

  integer_to_ascii_formatter dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .action(action), .value(value),
    .out_valid(out_valid), .out_ready(out_ready), .char_code(char_code), .last(last)
  );

  integer_to_ascii_formatter_checker chk (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .action(action), .value(value),
    .out_valid(out_valid), .out_ready(out_ready), .char_code(char_code), .last(last),
    .errors(errors), .pending(pending)
  );

  // Mostly back to back, sometimes a few cycles, now and then a long pause.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 24);
  endfunction

  function automatic logic [63:0] pick_value();
    logic [63:0] p;
    int          k;
    case ($urandom_range(0, 6))
      0, 1: return {$urandom, $urandom};
      2:    return {$urandom, $urandom} >> $urandom_range(1, 63);
      3:    return 64'(5'd0) + $urandom_range(0, 999);
      4:    return 64'd0 - 64'($urandom_range(1, 100000));
      5: begin
        // Around a power of ten, where the digit count changes.
        k = $urandom_range(0, 19);
        p = 64'd1;
        repeat (k) p = p * 64'd10;
        return p + 64'($urandom_range(0, 2)) - 64'd1;
      end
      default: begin
        p = 64'd1 << $urandom_range(0, 63);
        return p - 64'($urandom_range(0, 1));
      end
    endcase
  endfunction

  function automatic logic [1:0] pick_format();
    case ($urandom_range(0, 9))
      0, 1, 2: return FMT_SDEC;
      3, 4, 5: return FMT_UDEC;
      6, 7, 8: return FMT_HEX;
      default: return FMT_UNUSED;
    endcase
  endfunction

  // Receiver: out_ready changes at the falling edge only.
  always @(negedge clk) begin
    if (!rst) begin
      if (hold_req) begin
        hold_req = 1'b0;
        stall_left = HOLD_CYCLES;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (!rx_steady && $urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
    end
  end

  task automatic send_number(logic [1:0] fmt, logic [63:0] num);
    int gap;
    gap = tx_quiet ? 0 : pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    action   <= fmt;
    value    <= num;
    do @(posedge clk); while (!in_ready);
  endtask

  initial begin
    int waited;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: extremes of each format, every glyph, the unused code.
    send_number(FMT_SDEC, 64'd0);
    send_number(FMT_SDEC, 64'd1);
    send_number(FMT_SDEC, {64{1'b1}});
    send_number(FMT_SDEC, 64'h7fff_ffff_ffff_ffff);
    send_number(FMT_SDEC, 64'h8000_0000_0000_0000);
    send_number(FMT_SDEC, 64'd9876543210123456789);
    send_number(FMT_SDEC, 64'd0 - 64'd10);
    send_number(FMT_SDEC, 64'd1234567890);
    send_number(FMT_UDEC, 64'd0);
    send_number(FMT_UDEC, {64{1'b1}});
    send_number(FMT_UDEC, 64'd9876543210123456789);
    send_number(FMT_UDEC, 64'h8000_0000_0000_0000);
    send_number(FMT_UDEC, 64'd10);
    send_number(FMT_UDEC, 64'd9);
    send_number(FMT_HEX, 64'd0);
    send_number(FMT_HEX, {64{1'b1}});
    send_number(FMT_HEX, 64'h0123_4567_89ab_cdef);
    send_number(FMT_HEX, 64'hfedc_ba98_7654_3210);
    send_number(FMT_HEX, 64'ha);
    send_number(FMT_UNUSED, 64'd0);
    send_number(FMT_UNUSED, 64'h8000_0000_0000_0000);
    send_number(FMT_UNUSED, 64'hdead_beef);

    // Random with idling on both sides.
    repeat (98) send_number(pick_format(), pick_value());

    // Receiver holds off while the sender keeps offering items back to back.
    tx_quiet = 1'b1;
    hold_req = 1'b1;
    repeat (15) send_number(pick_format(), pick_value());

    // A stretch with no idling on either side.
    rx_steady = 1'b1;
    repeat (40) send_number(pick_format(), pick_value());

    tx_quiet  = 1'b0;
    rx_steady = 1'b0;
    repeat (35) send_number(pick_format(), pick_value());

    @(negedge clk);
    in_valid <= 1'b0;

    waited = 0;
    while (pending != 0 && waited < 20000) begin
      @(negedge clk);
      waited++;
    end
    repeat (50) @(negedge clk);

    if (errors == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
